### sv/alpl_pkg.sv
// ----------------------------------------------------------------------------
// alpl_pkg
// Shared widths, register indexes and controller/datapath bundles for the
// arc-length to curve-parameter lookup.
// ----------------------------------------------------------------------------
package alpl_pkg;

  localparam int WORD_W      = 32;  // Q16.16 values
  localparam int IDX_W       = 10;  // entry_index field
  localparam int ENTRIES_W   = 11;  // entries_in_use register
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_IDX_W-1:0] REG_ENTRIES_IN_USE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH   = 2'd1;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [ENTRIES_W-1:0] ENTRIES_RESET = 11'd2;

  // controller to datapath
  typedef struct packed {
    logic mem_wr;       // write the load word into the table
    logic query_start;  // capture clamped arc and search bounds
    logic rd_mid;       // read entry at search midpoint
    logic rd_lo;        // read lower bracket entry
    logic rd_hi;        // read upper bracket entry
    logic search_upd;   // move lo or hi to the midpoint
    logic latch_a;
    logic latch_b;
    logic div_init;     // resolve special cases, load divider
    logic div_step;
    logic mul_step;
    logic add_step;
    logic out_load;
  } alpl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic search_done;  // lo + 1 >= hi
    logic early;        // result known without interpolation
  } alpl_sts_t;

endpackage

### sv/alpl_if.sv
// ----------------------------------------------------------------------------
// alpl_in_if / alpl_out_if
// Valid/ready channels for the input words and the result words.
// ----------------------------------------------------------------------------
interface alpl_in_if;
  logic                           valid;
  logic                           ready;
  logic                           func;
  logic [alpl_pkg::IDX_W-1:0]     entry_index;
  logic [alpl_pkg::WORD_W-1:0]    entry_param;
  logic [alpl_pkg::WORD_W-1:0]    entry_arc;
  logic [alpl_pkg::WORD_W-1:0]    query_arc;

  modport source (output valid, func, entry_index, entry_param, entry_arc, query_arc,
                  input ready);
  modport sink   (input valid, func, entry_index, entry_param, entry_arc, query_arc,
                  output ready);
endinterface

interface alpl_out_if;
  logic                           valid;
  logic                           ready;
  logic [alpl_pkg::WORD_W-1:0]    param_out;
  logic                           degenerate;

  modport source (output valid, param_out, degenerate, input ready);
  modport sink   (input valid, param_out, degenerate, output ready);
endinterface

### sv/alpl_ctrl.sv
// ----------------------------------------------------------------------------
// alpl_ctrl
// Sequencer for one word at a time: table load, binary search, bracket
// reads, restoring divide, multiply, add, and the output handshake.
// ----------------------------------------------------------------------------
module alpl_ctrl #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_func,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output alpl_pkg::alpl_cmd_t   cmd,
  input  alpl_pkg::alpl_sts_t   sts
);

  localparam int CW = $clog2(FRACTION_BITS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEARCH,
    S_CMP,
    S_RD_B,
    S_LAT_B,
    S_CHECK,
    S_DIV,
    S_MUL,
    S_ADD,
    S_OUT
  } state_t;

  state_t          state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            accept;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign accept    = in_valid && in_ready;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;

    // drop the result word once taken
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_func == alpl_pkg::FUNC_QUERY) begin
            cmd.query_start = 1'b1;
            state_nxt       = S_SEARCH;
          end else begin
            cmd.mem_wr = 1'b1;
          end
        end
      end
      S_SEARCH: begin
        if (sts.search_done) begin
          cmd.rd_lo = 1'b1;
          state_nxt = S_RD_B;
        end else begin
          cmd.rd_mid = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        cmd.search_upd = 1'b1;
        state_nxt      = S_SEARCH;
      end
      S_RD_B: begin
        cmd.latch_a = 1'b1;
        cmd.rd_hi   = 1'b1;
        state_nxt   = S_LAT_B;
      end
      S_LAT_B: begin
        cmd.latch_b = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        cmd.div_init = 1'b1;
        cnt_nxt      = CW'(FRACTION_BITS - 1);
        state_nxt    = sts.early ? S_OUT : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_step = 1'b1;
        state_nxt    = S_ADD;
      end
      S_ADD: begin
        cmd.add_step = 1'b1;
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_load_only_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("result loaded over an untaken word");

  a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

  a_query_starts_search: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_func == alpl_pkg::FUNC_QUERY) |=> (state_r == S_SEARCH))
    else $error("query word did not start the search");

  a_div_ends_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && cnt_r == '0) |=> (state_r == S_MUL))
    else $error("divide did not finish after its last step");

  a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.div_step || cmd.search_upd) |-> !in_ready)
    else $error("input ready while a query is in flight");

endmodule

### sv/alpl_dp.sv
// ----------------------------------------------------------------------------
// alpl_dp
// Datapath: configuration registers, entry table memory, search bounds,
// bracket registers, restoring divider, multiplier and output register.
// ----------------------------------------------------------------------------
module alpl_dp #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [alpl_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [alpl_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [alpl_pkg::IDX_W-1:0]          entry_index,
  input  logic [alpl_pkg::WORD_W-1:0]         entry_param,
  input  logic [alpl_pkg::WORD_W-1:0]         entry_arc,
  input  logic [alpl_pkg::WORD_W-1:0]         query_arc,
  output logic [alpl_pkg::WORD_W-1:0]         param_out,
  output logic                                degenerate,
  input  alpl_pkg::alpl_cmd_t                 cmd,
  output alpl_pkg::alpl_sts_t                 sts
);

  localparam int W  = alpl_pkg::WORD_W;
  localparam int FB = FRACTION_BITS;
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int NW = (AW + 1 > alpl_pkg::ENTRIES_W) ? AW + 1 : alpl_pkg::ENTRIES_W;
  localparam int IW = (AW + 1 > alpl_pkg::IDX_W) ? AW + 1 : alpl_pkg::IDX_W;

  logic [alpl_pkg::ENTRIES_W-1:0] entries_r;
  logic [W-1:0]                   total_r;

  logic [2*W-1:0]  mem [TABLE_DEPTH];
  logic [2*W-1:0]  rd_data_r;
  logic [AW-1:0]   rd_addr;
  logic            rd_en;
  logic            wr_ok;

  logic [W-1:0]    arc_r;
  logic [AW-1:0]   lo_r, hi_r, mid;
  logic [AW:0]     mid_sum;
  logic [NW-1:0]   n_ext, n_clamp;

  logic [W-1:0]    pa_r, aa_r, pb_r, ab_r;
  logic            degen, arc_le_a, arc_ge_b;

  logic [W-1:0]    rem_r, den_r, diff_r;
  logic [W:0]      rem_sh, den_ext;
  logic            rem_ge;
  logic [FB-1:0]   q_r;
  logic            up_r;
  logic [W+FB-1:0] prod_r;
  logic [W-1:0]    step;

  logic [W-1:0]    res_r;
  logic            deg_r;
  logic [W-1:0]    out_param_r;
  logic            out_deg_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_r <= alpl_pkg::ENTRIES_RESET;
      total_r   <= '0;
    end else if (cfg_we) begin
      if (cfg_index == alpl_pkg::REG_ENTRIES_IN_USE) begin
        entries_r <= cfg_data[alpl_pkg::ENTRIES_W-1:0];
      end else if (cfg_index == alpl_pkg::REG_TOTAL_LENGTH) begin
        total_r <= cfg_data[W-1:0];
      end
    end
  end

  // table memory: word is {param, arc}
  assign wr_ok   = IW'(entry_index) < IW'(TABLE_DEPTH);
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign rd_en   = cmd.rd_mid || cmd.rd_lo || cmd.rd_hi;

  always_comb begin
    if (cmd.rd_mid) begin
      rd_addr = mid;
    end else if (cmd.rd_lo) begin
      rd_addr = lo_r;
    end else begin
      rd_addr = hi_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && wr_ok) begin
      mem[AW'(entry_index)] <= {entry_param, entry_arc};
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  // search bounds; entry count clamped to [2, TABLE_DEPTH]
  assign n_ext = NW'(entries_r);
  always_comb begin
    if (n_ext < NW'(2)) begin
      n_clamp = NW'(2);
    end else if (n_ext > NW'(TABLE_DEPTH)) begin
      n_clamp = NW'(TABLE_DEPTH);
    end else begin
      n_clamp = n_ext;
    end
  end

  assign sts.search_done = !(({1'b0, lo_r} + 1'b1) < {1'b0, hi_r});

  always_ff @(posedge clk) begin
    if (cmd.query_start) begin
      arc_r <= (query_arc > total_r) ? total_r : query_arc;
      lo_r  <= '0;
      hi_r  <= AW'(n_clamp - 1'b1);
    end else if (cmd.search_upd) begin
      if (rd_data_r[W-1:0] <= arc_r) begin
        lo_r <= mid;
      end else begin
        hi_r <= mid;
      end
    end
  end

  // bracket entries
  always_ff @(posedge clk) begin
    if (cmd.latch_a) begin
      pa_r <= rd_data_r[2*W-1:W];
      aa_r <= rd_data_r[W-1:0];
    end
    if (cmd.latch_b) begin
      pb_r <= rd_data_r[2*W-1:W];
      ab_r <= rd_data_r[W-1:0];
    end
  end

  assign degen     = (ab_r <= aa_r);
  assign arc_le_a  = (arc_r <= aa_r);
  assign arc_ge_b  = (arc_r >= ab_r);
  assign sts.early = degen || arc_le_a || arc_ge_b;

  // restoring divide, one quotient bit per step
  assign rem_sh  = {rem_r, 1'b0};
  assign den_ext = {1'b0, den_r};
  assign rem_ge  = (rem_sh >= den_ext);
  assign step    = prod_r[FB +: W];

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem_r  <= arc_r - aa_r;
      den_r  <= ab_r - aa_r;
      q_r    <= '0;
      up_r   <= (pb_r >= pa_r);
      diff_r <= (pb_r >= pa_r) ? (pb_r - pa_r) : (pa_r - pb_r);
      deg_r  <= degen;
      res_r  <= (degen || arc_le_a) ? pa_r : pb_r;
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? W'(rem_sh - den_ext) : rem_sh[W-1:0];
      q_r   <= {q_r[FB-2:0], rem_ge};
    end else if (cmd.mul_step) begin
      prod_r <= diff_r * q_r;
    end else if (cmd.add_step) begin
      // truncate toward the lower bracket's parameter
      res_r <= up_r ? (pa_r + step) : (pa_r - step);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_param_r <= res_r;
      out_deg_r   <= deg_r;
    end
  end

  assign param_out  = out_param_r;
  assign degenerate = out_deg_r;

endmodule

### sv/arc_length_to_parameter_lookup.sv
// Load word: the next word is accepted in the following cycle.
// Query word: a binary search over the table, the lower and upper bracket reads, then
//   a bit-serial restoring divide, a multiply and an add; with no interpolation the
//   result loads straight after the bracket check. Next word in the cycle after the
//   result loads; an untaken earlier result holds the load back.
// Reset (rst_n low, synchronous): entries_in_use = 2, total_length = 0, no result pending.
// ----------------------------------------------------------------------------
// arc_length_to_parameter_lookup
// Arc-length to curve-parameter conversion by binary search over a loaded
// table of (parameter, arc) entries and linear interpolation.
// ----------------------------------------------------------------------------
module arc_length_to_parameter_lookup #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  alpl_in_if.sink                          in_ch,
  alpl_out_if.source                       out_ch,
  input  logic                             cfg_we,
  input  logic [alpl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alpl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  alpl_pkg::alpl_cmd_t cmd;
  alpl_pkg::alpl_sts_t sts;
  logic                in_ready;
  logic                out_valid;
  logic [alpl_pkg::WORD_W-1:0] param_out;
  logic                degenerate;

  alpl_ctrl #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_func   (in_ch.func),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  alpl_dp #(
    .TABLE_DEPTH   (TABLE_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .entry_index (in_ch.entry_index),
    .entry_param (in_ch.entry_param),
    .entry_arc   (in_ch.entry_arc),
    .query_arc   (in_ch.query_arc),
    .param_out   (param_out),
    .degenerate  (degenerate),
    .cmd         (cmd),
    .sts         (sts)
  );

  assign in_ch.ready       = in_ready;
  assign out_ch.valid      = out_valid;
  assign out_ch.param_out  = param_out;
  assign out_ch.degenerate = degenerate;

endmodule

### sim/param_lookup_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// param_lookup_checker
// Watches the input, result and register ports of the arc-length lookup,
// keeps its own copy of the tables and registers, predicts the parameter of
// every accepted query and compares it against the result words in order.
// ----------------------------------------------------------------------------
module param_lookup_checker #(
  parameter int TABLE_DEPTH   = 1024,
  parameter int FRACTION_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  alpl_in_if                              in_mon,
  alpl_out_if                             out_mon,
  input  logic                            cfg_we,
  input  logic [alpl_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [alpl_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              outstanding
);

  typedef struct packed {
    logic [alpl_pkg::WORD_W-1:0] param;
    logic                        degenerate;
  } lookup_t;

  logic [alpl_pkg::WORD_W-1:0]    param_tab [TABLE_DEPTH];
  logic [alpl_pkg::WORD_W-1:0]    arc_tab   [TABLE_DEPTH];
  logic [alpl_pkg::ENTRIES_W-1:0] entries_reg;
  logic [alpl_pkg::WORD_W-1:0]    length_reg;
  lookup_t                        expected_params [$];
  int                             err_cnt = 0;

  assign mismatches = err_cnt;

  task automatic flag_mismatch(input string what);
    $display("%0t ns lookup mismatch: %s", $time, what);
    err_cnt++;
  endtask

  function automatic lookup_t convert_arc(input logic [alpl_pkg::WORD_W-1:0] query);
    int unsigned                 n, lo, hi, mid;
    logic [alpl_pkg::WORD_W-1:0] arc, aa, ab, pa, pb;
    logic [63:0]                 num, den, frac, span;
    lookup_t                     r;
    n = entries_reg;
    if (n < 2) n = 2;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    arc = (query > length_reg) ? length_reg : query;
    lo = 0;
    hi = n - 1;
    while (lo + 1 < hi) begin
      mid = (lo + hi) >> 1;
      if (arc_tab[mid] <= arc) lo = mid;
      else hi = mid;
    end
    aa = arc_tab[lo];
    ab = arc_tab[hi];
    pa = param_tab[lo];
    pb = param_tab[hi];
    r.degenerate = 1'b0;
    if (ab <= aa) begin
      r.param      = pa;
      r.degenerate = 1'b1;
    end else if (arc <= aa) begin
      r.param = pa;
    end else if (arc >= ab) begin
      r.param = pb;
    end else begin
      // floor of the scaled ratio, same as the bit-serial restoring divide
      num  = {32'b0, arc - aa};
      den  = {32'b0, ab - aa};
      frac = (num << FRACTION_BITS) / den;
      if (pb >= pa) begin
        span    = ({32'b0, pb - pa} * frac) >> FRACTION_BITS;
        r.param = pa + span[alpl_pkg::WORD_W-1:0];
      end else begin
        span    = ({32'b0, pa - pb} * frac) >> FRACTION_BITS;
        r.param = pa - span[alpl_pkg::WORD_W-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    lookup_t want;
    if (!rst_n) begin
      entries_reg = alpl_pkg::ENTRIES_RESET;
      length_reg  = '0;
      expected_params.delete();
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          alpl_pkg::REG_ENTRIES_IN_USE: entries_reg = cfg_data[alpl_pkg::ENTRIES_W-1:0];
          alpl_pkg::REG_TOTAL_LENGTH:   length_reg  = cfg_data[alpl_pkg::WORD_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) begin
        if (expected_params.size() == 0) begin
          flag_mismatch($sformatf("result word %h/%b with no query pending",
                                  out_mon.param_out, out_mon.degenerate));
        end else begin
          want = expected_params.pop_front();
          if (out_mon.param_out !== want.param)
            flag_mismatch($sformatf("param_out %h, predicted %h",
                                    out_mon.param_out, want.param));
          if (out_mon.degenerate !== want.degenerate)
            flag_mismatch($sformatf("degenerate %b, predicted %b",
                                    out_mon.degenerate, want.degenerate));
        end
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) begin
        if (in_mon.func == alpl_pkg::FUNC_LOAD) begin
          if (in_mon.entry_index < TABLE_DEPTH) begin
            param_tab[in_mon.entry_index] = in_mon.entry_param;
            arc_tab[in_mon.entry_index]   = in_mon.entry_arc;
          end
        end else begin
          expected_params = {expected_params, convert_arc(in_mon.query_arc)};
        end
      end
      outstanding <= expected_params.size();
    end
  end

endmodule

### sim/arc_length_to_parameter_lookup_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arc_length_to_parameter_lookup_tb
// Loads ascending (parameter, arc) tables, programs entry count and total
// length over several settings, and sends directed then random query and
// load words with random gaps and result stalls; the checker scores results.
// ----------------------------------------------------------------------------
module arc_length_to_parameter_lookup_tb;

  localparam int DEPTH = 1024;
  localparam int FBITS = 16;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [alpl_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [alpl_pkg::CFG_DATA_W-1:0] cfg_data;
  bit                              calm;
  int                              mismatches;
  int                              outstanding;
  logic [alpl_pkg::WORD_W-1:0]     arc_img [DEPTH];  // loaded arcs, used to aim queries
  int unsigned                     n_live;
  logic [alpl_pkg::WORD_W-1:0]     len_live;
  int unsigned                     cnt;

  alpl_in_if  in_ch ();
  alpl_out_if out_ch ();

  arc_length_to_parameter_lookup #(
    .TABLE_DEPTH  (DEPTH),
    .FRACTION_BITS(FBITS)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  param_lookup_checker #(
    .TABLE_DEPTH  (DEPTH),
    .FRACTION_BITS(FBITS)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .outstanding(outstanding)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    out_ch.ready <= calm || ($urandom_range(99) >= 32);
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_word(input logic f, input logic [alpl_pkg::IDX_W-1:0] idx,
                           input logic [alpl_pkg::WORD_W-1:0] p,
                           input logic [alpl_pkg::WORD_W-1:0] a,
                           input logic [alpl_pkg::WORD_W-1:0] q);
    if (!calm) begin
      while ($urandom_range(99) < 32) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= f;
    in_ch.entry_index <= idx;
    in_ch.entry_param <= p;
    in_ch.entry_arc   <= a;
    in_ch.query_arc   <= q;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    if (f == alpl_pkg::FUNC_LOAD) arc_img[idx] = a;
  endtask

  task automatic load_entry(input int unsigned idx, input logic [alpl_pkg::WORD_W-1:0] p,
                            input logic [alpl_pkg::WORD_W-1:0] a);
    send_word(alpl_pkg::FUNC_LOAD, idx[alpl_pkg::IDX_W-1:0], p, a, $urandom());
  endtask

  task automatic query(input logic [alpl_pkg::WORD_W-1:0] q);
    int unsigned slot;
    slot = $urandom_range(DEPTH - 1);
    send_word(alpl_pkg::FUNC_QUERY, slot[alpl_pkg::IDX_W-1:0], $urandom(), $urandom(), q);
  endtask

  // drop valid and wait until every query has answered and a load has landed
  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_regs(input logic [alpl_pkg::CFG_DATA_W-1:0] n_cfg,
                          input logic [alpl_pkg::CFG_DATA_W-1:0] len);
    cfg_we    <= 1'b1;
    cfg_index <= alpl_pkg::REG_ENTRIES_IN_USE;
    cfg_data  <= n_cfg;
    @(posedge clk);
    cfg_index <= alpl_pkg::REG_TOTAL_LENGTH;
    cfg_data  <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_live = n_cfg[alpl_pkg::ENTRIES_W-1:0];
    if (n_live < 2) n_live = 2;
    if (n_live > DEPTH) n_live = DEPTH;
    len_live = len[alpl_pkg::WORD_W-1:0];
  endtask

  // ascending arcs from slot 0, with occasional flat steps
  task automatic fill_table(input int unsigned count, input int unsigned flat_pct);
    int unsigned                 i;
    logic [alpl_pkg::WORD_W-1:0] arc, stride;
    stride = 32'hFFFF_FFFF / count;
    arc    = $urandom_range(stride);
    for (i = 0; i < count; i++) begin
      load_entry(i, $urandom(), arc);
      if ($urandom_range(99) >= flat_pct) arc = arc + $urandom_range(stride);
    end
  endtask

  task automatic random_items(input int unsigned count);
    int unsigned                 k, k1, sel;
    logic [alpl_pkg::WORD_W-1:0] q, lo_a, hi_a;
    repeat (count) begin
      k  = $urandom_range(n_live - 1);
      k1 = (k + 1 < n_live) ? k + 1 : k;
      if ($urandom_range(99) < 70) begin
        case ($urandom_range(7))
          0:       q = arc_img[k];
          1:       q = arc_img[k] + 1;
          2:       q = arc_img[k] - 1;
          3:       q = arc_img[k] + ((arc_img[k1] - arc_img[k]) >> 1);
          4:       q = $urandom_range(arc_img[k1], arc_img[k]);
          5:       q = $urandom();
          6:       q = len_live + $urandom_range(3);
          default: q = $urandom_range(1) ? '1 : '0;
        endcase
        query(q);
      end else begin
        sel = $urandom_range(99);
        if (sel < 70) begin
          // rewrite an entry between its neighbors
          lo_a = (k > 0) ? arc_img[k - 1] : '0;
          hi_a = (k + 1 < n_live) ? arc_img[k + 1] : '1;
          load_entry(k, $urandom(), $urandom_range(hi_a, lo_a));
        end else if (sel < 85) begin
          load_entry(k, $urandom(), (k > 0) ? arc_img[k - 1] : arc_img[k1]);
        end else begin
          load_entry($urandom_range(DEPTH - 1), $urandom(), $urandom());
        end
      end
    end
  endtask

  initial begin
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= alpl_pkg::REG_ENTRIES_IN_USE;
    cfg_data          <= '0;
    calm              = 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.func        <= alpl_pkg::FUNC_LOAD;
    in_ch.entry_index <= '0;
    in_ch.entry_param <= '0;
    in_ch.entry_arc   <= '0;
    in_ch.query_arc   <= '0;
    n_live            = 2;
    len_live          = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: total length zero clamps every query to the start
    load_entry(0, 32'h0000_0000, 32'h0000_0100);
    load_entry(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    query(32'h8000_0000);
    settle();

    // entry count zero acts as two
    set_regs(0, 32'hFFFF_FFFF);
    query(32'h0000_0000);
    query(32'h0000_0100);
    query(32'h0000_0101);
    query(32'h8000_0000);
    query(32'hFFFF_FFFF);
    load_entry(1, 32'h0000_0000, 32'h0000_0100);
    query(32'h0000_0100);
    query(32'hFFFF_FFFF);
    load_entry(1, 32'h0001_0000, 32'h0000_0050);
    query(32'h0000_0080);
    load_entry(1, 32'h0000_0000, 32'h0010_0000);
    load_entry(0, 32'hFFFF_FFFF, 32'h0000_0000);
    query(32'h0008_0000);
    load_entry(DEPTH - 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    settle();

    // entry count one acts as two, clamp inside the bracket
    set_regs(1, 32'h0008_0000);
    query(32'hFFFF_FFFF);
    query(32'h0004_0000);
    query(32'h0000_0000);
    settle();

    fill_table(3, 10);
    settle();
    set_regs(3, arc_img[2]);
    random_items(50);
    settle();

    cnt = $urandom_range(16, 4);
    fill_table(cnt, 15);
    settle();
    set_regs(cnt, $urandom());
    random_items(60);
    settle();

    // no gaps and no stalls in this stretch
    calm = 1'b1;
    cnt  = $urandom_range(64, 17);
    fill_table(cnt, 10);
    settle();
    set_regs(cnt, arc_img[cnt / 2]);
    random_items(60);
    settle();
    calm = 1'b0;

    // entry count above the table depth acts as the depth; slots 511, 255 and 127
    // hold the top arc so every search walks down into the filled low slots
    fill_table(128, 10);
    load_entry(127, $urandom(), 32'hFFFF_FFFF);
    load_entry(255, $urandom(), 32'hFFFF_FFFF);
    load_entry(511, $urandom(), 32'hFFFF_FFFF);
    settle();
    set_regs(2047, arc_img[64]);
    repeat (30) query($urandom());
    settle();

    set_regs(128, $urandom());
    random_items(80);
    settle();

    cnt = $urandom_range(40, 2);
    fill_table(cnt, 10);
    settle();
    set_regs(cnt, 32'h0000_0000);
    random_items(50);
    settle();

    set_regs($urandom_range(128, 65), $urandom());
    random_items(60);

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (64) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
